// ----- sv/bcc_pkg.sv -----
// shared types and constants of the button click classifier
package bcc_pkg;

  localparam int unsigned TickBitsDefault = 16;
  localparam int unsigned ThreshW         = 16;
  localparam int unsigned AddrW           = 4;
  localparam int unsigned DataW           = 32;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_IDLE_LEVEL   = 2'd0;
  localparam logic [1:0] REG_DOUBLE_WIN   = 2'd1;
  localparam logic [1:0] REG_LONG_HOLD    = 2'd2;
  localparam logic [1:0] REG_EVENT_ENABLE = 2'd3;

  // reported event codes
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_SINGLE = 2'd1;
  localparam logic [1:0] EV_DOUBLE = 2'd2;
  localparam logic [1:0] EV_LONG   = 2'd3;

  // bits of the event enable register
  localparam int unsigned EN_SINGLE_BIT = 0;
  localparam int unsigned EN_DOUBLE_BIT = 1;
  localparam int unsigned EN_LONG_BIT   = 2;

  localparam logic [ThreshW-1:0] DoubleWinReset = 16'd20;
  localparam logic [ThreshW-1:0] LongHoldReset  = 16'd100;

  typedef struct packed {
    logic               idle_level;
    logic [ThreshW-1:0] double_window_ticks;
    logic [ThreshW-1:0] long_hold_ticks;
    logic [2:0]         event_enable;
    logic               idle_load;      // pulse: idle_level written this cycle
    logic               idle_load_val;  // value being written
  } cfg_t;

endpackage

// ----- sv/bcc_cfg.sv -----
// apb register file of the button click classifier
module bcc_cfg
  import bcc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  logic               idle_level_q, idle_level_d;
  logic [ThreshW-1:0] double_win_q, double_win_d;
  logic [ThreshW-1:0] long_hold_q, long_hold_d;
  logic [2:0]         event_en_q, event_en_d;
  logic               wr_en;
  logic [1:0]         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  always_comb begin
    idle_level_d = idle_level_q;
    double_win_d = double_win_q;
    long_hold_d  = long_hold_q;
    event_en_d   = event_en_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_IDLE_LEVEL:   idle_level_d = pwdata[0];
        REG_DOUBLE_WIN:   double_win_d = pwdata[ThreshW-1:0];
        REG_LONG_HOLD:    long_hold_d  = pwdata[ThreshW-1:0];
        REG_EVENT_ENABLE: event_en_d   = pwdata[2:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_level_q <= 1'b0;
      double_win_q <= DoubleWinReset;
      long_hold_q  <= LongHoldReset;
      event_en_q   <= 3'd0;
    end else begin
      idle_level_q <= idle_level_d;
      double_win_q <= double_win_d;
      long_hold_q  <= long_hold_d;
      event_en_q   <= event_en_d;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_IDLE_LEVEL:   prdata = DataW'(idle_level_q);
      REG_DOUBLE_WIN:   prdata = DataW'(double_win_q);
      REG_LONG_HOLD:    prdata = DataW'(long_hold_q);
      REG_EVENT_ENABLE: prdata = DataW'(event_en_q);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    cfg_o.idle_level          = idle_level_q;
    cfg_o.double_window_ticks = double_win_q;
    cfg_o.long_hold_ticks     = long_hold_q;
    cfg_o.event_enable        = event_en_q;
    cfg_o.idle_load           = wr_en && (reg_idx == REG_IDLE_LEVEL);
    cfg_o.idle_load_val       = pwdata[0];
  end

endmodule

// ----- sv/bcc_core.sv -----
// press classification state machine, advanced once per sample
module bcc_core
  import bcc_pkg::*;
#(
  parameter int unsigned TICK_BITS = TickBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       step_i,
  input  logic       level_i,
  output logic [1:0] event_code_o
);

  localparam int unsigned CmpW = (TICK_BITS > ThreshW) ? TICK_BITS : ThreshW;

  localparam logic [1:0] PH_IDLE          = 2'd0;
  localparam logic [1:0] PH_FIRST_PRESS   = 2'd1;
  localparam logic [1:0] PH_FIRST_RELEASE = 2'd2;
  localparam logic [1:0] PH_SECOND_PRESS  = 2'd3;

  logic [1:0]           phase_q, phase_d;
  logic [TICK_BITS-1:0] cnt_q, cnt_d;
  logic                 prior_q, prior_d;
  logic [TICK_BITS-1:0] cnt_inc;
  logic                 steady;
  logic                 long_hit;
  logic                 win_hit;
  logic [1:0]           ev;

  // saturating count of steady ticks
  assign cnt_inc  = (&cnt_q) ? cnt_q : cnt_q + 1'b1;
  assign steady   = (level_i == prior_q);
  assign long_hit = CmpW'(cnt_inc) >= CmpW'(cfg_i.long_hold_ticks);
  assign win_hit  = CmpW'(cnt_inc) >= CmpW'(cfg_i.double_window_ticks);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    ev      = EV_NONE;
    unique case (phase_q)
      PH_IDLE: begin
        if (level_i != cfg_i.idle_level && prior_q == cfg_i.idle_level) begin
          phase_d = PH_FIRST_PRESS;
        end
      end
      PH_FIRST_PRESS: begin
        if (steady) begin
          cnt_d = cnt_inc;
          if (long_hit) begin
            cnt_d   = '0;
            phase_d = PH_IDLE;
            if (cfg_i.event_enable[EN_LONG_BIT]) ev = EV_LONG;
          end
        end else begin
          cnt_d   = '0;
          phase_d = PH_FIRST_RELEASE;
        end
      end
      PH_FIRST_RELEASE: begin
        if (steady) begin
          cnt_d = cnt_inc;
          if (win_hit) begin
            cnt_d   = '0;
            phase_d = PH_IDLE;
            if (cfg_i.event_enable[EN_SINGLE_BIT]) ev = EV_SINGLE;
          end
        end else begin
          cnt_d   = '0;
          phase_d = PH_SECOND_PRESS;
        end
      end
      PH_SECOND_PRESS: begin
        // no timeout here, only the release ends it
        if (!steady) begin
          phase_d = PH_IDLE;
          if (cfg_i.event_enable[EN_DOUBLE_BIT]) ev = EV_DOUBLE;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_comb begin
    prior_d = prior_q;
    if (step_i) begin
      prior_d = level_i;
    end else if (cfg_i.idle_load) begin
      prior_d = cfg_i.idle_load_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      prior_q <= 1'b0;
    end else begin
      prior_q <= prior_d;
      if (step_i) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  assign event_code_o = ev;

endmodule

// ----- sv/button_click_classifier_top.sv -----
// top level of the button click classifier: stream ports, pipeline, registers
//
// Usage:
//   The slave stream carries one sampled button level per scan tick in
//   s_axis_tdata[0]. The master stream returns exactly one event per sample
//   in m_axis_tdata[1:0]: none, single click, double click or long press.
//   Registers (idle level, double window, long hold, event enable) are set
//   through the apb port while no sample is in flight.
// Pipeline and throughput:
//   A sample is registered on input, classified once the output slot is
//   free, and its event lands in the output register for the master
//   stream. One sample per cycle is taken in steady state while
//   m_axis_tready stays high; the state register feedback sets that rate.
// Reset:
//   rst_ni clears the pipeline, returns the machine to idle with a zero
//   tick count and loads the register reset values.
// Stalls:
//   When the receiver holds m_axis_tready low the result stays put, an
//   empty input register still takes one more sample, then s_axis_tready drops.
module button_click_classifier_top
  import bcc_pkg::*;
#(
  parameter int unsigned TICK_BITS = TickBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // apb configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  // sample stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [0] level, [7:1] zero
  // event stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata    // [1:0] event_code, [7:2] zero
);

  cfg_t       cfg;
  logic       in_valid_q, in_valid_d;
  logic       in_level_q;
  logic       out_valid_q, out_valid_d;
  logic [1:0] out_code_q;
  logic [1:0] core_ev;
  logic       out_free;
  logic       step;
  logic       s_xfer;
  logic       m_xfer;

  bcc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bcc_core #(
    .TICK_BITS (TICK_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .step_i       (step),
    .level_i      (in_level_q),
    .event_code_o (core_ev)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign m_xfer        = out_valid_q && m_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_xfer) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (m_xfer) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_level_q <= s_axis_tdata[0];
    end
    if (step) begin
      out_code_q <= core_ev;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_code_q};

  // a held input slot only blocks while the output slot is held too
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a blocked output");

  a_long_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && core_ev == EV_LONG) |-> cfg.event_enable[EN_LONG_BIT])
    else $error("long press reported while disabled");

  a_single_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && core_ev == EV_SINGLE) |-> cfg.event_enable[EN_SINGLE_BIT])
    else $error("single click reported while disabled");

  a_double_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && core_ev == EV_DOUBLE) |-> cfg.event_enable[EN_DOUBLE_BIT])
    else $error("double click reported while disabled");

endmodule
